### rtl/core/line_editor_escape_keys_assert.svh
// ---------------------------------------------------------------------------
// line editor assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef LINE_EDITOR_ESCAPE_KEYS_ASSERT_SVH
`define LINE_EDITOR_ESCAPE_KEYS_ASSERT_SVH

`ifndef SYNTHESIS
// checked on every clock edge while reset is released
`define LEK_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("line editor assertion failed");
// checked on every clock edge, reset included
`define LEK_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("line editor assertion failed");
`else
`define LEK_ASSERT(name, prop)
`define LEK_ASSERT_ALWAYS(name, prop)
`endif

`endif

### rtl/core/lnedit_pkg.sv
// ---------------------------------------------------------------------------
// line editor package
// sizes, event codes and the controller to datapath command and status types
// ---------------------------------------------------------------------------
`default_nettype none

package lnedit_pkg;

  // line buffer size, the line holds one byte less
  localparam int unsigned LineBytes = 64;
  localparam int unsigned AddrW     = $clog2(LineBytes);
  localparam int unsigned LenW      = 6;

  // event codes
  localparam logic [3:0] EvInserted  = 4'd0;
  localparam logic [3:0] EvDropped   = 4'd1;
  localparam logic [3:0] EvBackspace = 4'd2;
  localparam logic [3:0] EvUp        = 4'd3;
  localparam logic [3:0] EvDown      = 4'd4;
  localparam logic [3:0] EvLeft      = 4'd5;
  localparam logic [3:0] EvRight     = 4'd6;
  localparam logic [3:0] EvDelete    = 4'd7;
  localparam logic [3:0] EvLineChar  = 4'd8;
  localparam logic [3:0] EvEmptyLine = 4'd9;
  localparam logic [3:0] EvIgnored   = 4'd10;

  // pointer register operation
  typedef enum logic [2:0] {
    PtrHold,
    PtrCount,
    PtrZero,
    PtrDec,
    PtrInc
  } ptr_op_e;

  // line store read address source
  typedef enum logic [1:0] {
    RdIns,
    RdRem,
    RdWin,
    RdLine
  } rd_sel_e;

  // output beat source
  typedef enum logic {
    OutStep,
    OutLine
  } out_sel_e;

  typedef struct packed {
    logic       load_byte;
    logic       ev_load;
    logic [3:0] ev_code;
    ptr_op_e    ptr_op;
    logic       clear_line;
    logic       ins_commit;
    logic       rd_en;
    rd_sel_e    rd_sel;
    logic       wr_en;
    logic       wr_byte;
    logic       eval;
    logic       out_load;
    out_sel_e   out_sel;
  } cmd_t;

  typedef struct packed {
    logic byte_zero;
    logic byte_eol;
    logic line_empty;
    logic line_full;
    logic ins_more;
    logic rem_more;
    logic win_last;
    logic line_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### rtl/core/lnedit_ctrl.sv
// ---------------------------------------------------------------------------
// line editor controller
// sequences insert shift, key match, removal shift and line streaming
// ---------------------------------------------------------------------------
`default_nettype none

module lnedit_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lnedit_pkg::status_t status_i,
  output lnedit_pkg::cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    StIdle      = 10'b00_0000_0001,
    StDecode    = 10'b00_0000_0010,
    StInsShift  = 10'b00_0000_0100,
    StInsWrite  = 10'b00_0000_1000,
    StMatchRd   = 10'b00_0001_0000,
    StMatchEval = 10'b00_0010_0000,
    StRemove    = 10'b00_0100_0000,
    StEmit      = 10'b00_1000_0000,
    StLineRd    = 10'b01_0000_0000,
    StLineEmit  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  // next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.ev_code  = lnedit_pkg::EvIgnored;
    cmd_o.ptr_op   = lnedit_pkg::PtrHold;
    cmd_o.rd_sel   = lnedit_pkg::RdLine;
    cmd_o.out_sel  = lnedit_pkg::OutStep;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_byte = 1'b1;
          state_d         = StDecode;
        end
      end
      StDecode: begin
        cmd_o.ev_load = 1'b1;
        if (status_i.byte_zero) begin
          cmd_o.ev_code = lnedit_pkg::EvIgnored;
          state_d       = StEmit;
        end else if (status_i.byte_eol) begin
          cmd_o.ev_code = lnedit_pkg::EvEmptyLine;
          if (status_i.line_empty) begin
            cmd_o.clear_line = 1'b1;
            state_d          = StEmit;
          end else begin
            cmd_o.ptr_op = lnedit_pkg::PtrZero;
            state_d      = StLineRd;
          end
        end else if (status_i.line_full) begin
          cmd_o.ev_code = lnedit_pkg::EvDropped;
          state_d       = StMatchRd;
        end else begin
          cmd_o.ev_code = lnedit_pkg::EvInserted;
          cmd_o.ptr_op  = lnedit_pkg::PtrCount;
          state_d       = StInsShift;
        end
      end
      // open a gap at the cursor, top byte first
      StInsShift: begin
        if (status_i.ins_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = lnedit_pkg::RdIns;
          cmd_o.wr_en  = 1'b1;
          cmd_o.ptr_op = lnedit_pkg::PtrDec;
        end else begin
          state_d = StInsWrite;
        end
      end
      StInsWrite: begin
        cmd_o.wr_en      = 1'b1;
        cmd_o.wr_byte    = 1'b1;
        cmd_o.ins_commit = 1'b1;
        state_d          = StMatchRd;
      end
      // fetch the four bytes before the cursor
      StMatchRd: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = lnedit_pkg::RdWin;
        if (status_i.win_last) begin
          state_d = StMatchEval;
        end
      end
      StMatchEval: begin
        cmd_o.eval = 1'b1;
        state_d    = StRemove;
      end
      // close the removed span, bottom byte first
      StRemove: begin
        if (status_i.rem_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = lnedit_pkg::RdRem;
          cmd_o.wr_en  = 1'b1;
          cmd_o.ptr_op = lnedit_pkg::PtrInc;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = lnedit_pkg::OutStep;
          state_d        = StIdle;
        end
      end
      StLineRd: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = lnedit_pkg::RdLine;
        state_d      = StLineEmit;
      end
      StLineEmit: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = lnedit_pkg::OutLine;
          if (status_i.line_last) begin
            cmd_o.clear_line = 1'b1;
            state_d          = StIdle;
          end else begin
            cmd_o.ptr_op = lnedit_pkg::PtrInc;
            state_d      = StLineRd;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/lnedit_dpath.sv
// ---------------------------------------------------------------------------
// line editor datapath
// line store, length and cursor, key match window and output register
// ---------------------------------------------------------------------------
`default_nettype none

`include "line_editor_escape_keys_assert.svh"

module lnedit_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lnedit_pkg::cmd_t    cmd_i,
  output lnedit_pkg::status_t status_o,
  input  logic [7:0]          key_byte_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [3:0]          event_res_o,
  output logic [7:0]          echo_char_o,
  output logic [7:0]          line_char_o,
  output logic                last_o,
  output logic [5:0]          line_length_o,
  output logic [5:0]          cursor_position_o
);

  localparam int unsigned AW = lnedit_pkg::AddrW;

  localparam logic [7:0] KeyBackspace = 8'h7f;
  localparam logic [7:0] KeyEsc       = 8'h1b;
  localparam logic [7:0] KeyBracket   = 8'h5b;
  localparam logic [7:0] KeyUp        = 8'h41;
  localparam logic [7:0] KeyDown      = 8'h42;
  localparam logic [7:0] KeyLeft      = 8'h44;
  localparam logic [7:0] KeyRight     = 8'h43;
  localparam logic [7:0] KeyThree     = 8'h33;
  localparam logic [7:0] KeyTilde     = 8'h7e;
  localparam logic [7:0] KeyCr        = 8'h0d;
  localparam logic [7:0] KeyLf        = 8'h0a;
  localparam logic [7:0] PrintLo      = 8'd32;
  localparam logic [7:0] PrintHi      = 8'd126;
  localparam logic [7:0] EchoUnknown  = 8'd63;
  localparam logic [7:0] EchoNewline  = 8'd10;

  // echo value of a received byte
  function automatic logic [7:0] echo_of(input logic [7:0] b);
    logic [7:0] e;
    if (b == 8'd0) begin
      e = 8'd0;
    end else if (b == KeyCr || b == KeyLf) begin
      e = EchoNewline;
    end else if (b >= PrintLo && b <= PrintHi) begin
      e = b;
    end else begin
      e = EchoUnknown;
    end
    return e;
  endfunction

  logic [7:0]    byte_q;
  logic [3:0]    ev_q, ev_eval;
  logic [AW-1:0] count_q, count_d;
  logic [AW-1:0] cursor_q, cursor_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [2:0]    rem_q, rem_eval;
  logic [1:0]    k_q;
  logic          cap_q;
  logic [7:0]    win_q [3];

  logic [7:0]    mem_q [lnedit_pkg::LineBytes];
  logic [7:0]    rd_data_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en_q;
  logic          wr_byte_q;
  logic [AW-1:0] wr_addr_q;
  logic [7:0]    wr_data;

  logic          out_valid_q;
  logic [3:0]    out_ev_q;
  logic [7:0]    out_echo_q;
  logic [7:0]    out_char_q;
  logic          out_last_q;
  logic [AW-1:0] out_len_q;
  logic [AW-1:0] out_cur_q;

  logic [7:0]    b1, b2, b3, b4;
  logic          esc3, hit_bs, hit_up, hit_down, hit_left, hit_right, hit_del;
  logic [AW-1:0] base1, base3, base4, avail, start_eval, cur_eval;

  // status toward the controller
  assign status_o.byte_zero  = (byte_q == 8'd0);
  assign status_o.byte_eol   = (byte_q == KeyCr) || (byte_q == KeyLf);
  assign status_o.line_empty = (count_q == '0);
  assign status_o.line_full  = (count_q >= AW'(lnedit_pkg::LineBytes - 1));
  assign status_o.ins_more   = (ptr_q > cursor_q);
  assign status_o.rem_more   = (ptr_q < count_q);
  assign status_o.win_last   = (k_q == 2'd3);
  assign status_o.line_last  = (ptr_q == count_q - AW'(1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // key match over the bytes before the cursor, newest is the read data
  always_comb begin
    b1         = rd_data_q;
    b2         = win_q[2];
    b3         = win_q[1];
    b4         = win_q[0];
    base1      = cursor_q - AW'(1);
    base3      = cursor_q - AW'(3);
    base4      = cursor_q - AW'(4);
    esc3       = (cursor_q >= AW'(3)) && (b3 == KeyEsc) && (b2 == KeyBracket);
    hit_bs     = (cursor_q != '0) && (b1 == KeyBackspace);
    hit_up     = esc3 && (b1 == KeyUp);
    hit_down   = esc3 && (b1 == KeyDown);
    hit_left   = esc3 && (b1 == KeyLeft);
    hit_right  = esc3 && (b1 == KeyRight);
    hit_del    = (cursor_q >= AW'(4)) && (b4 == KeyEsc) && (b3 == KeyBracket) &&
                 (b2 == KeyThree) && (b1 == KeyTilde);
    ev_eval    = ev_q;
    start_eval = count_q;
    rem_eval   = 3'd0;
    cur_eval   = cursor_q;
    avail      = '0;
    if (hit_bs) begin
      // key byte plus the byte before it, or the one after at line start
      ev_eval    = lnedit_pkg::EvBackspace;
      start_eval = (base1 == '0) ? '0 : base1 - AW'(1);
      avail      = count_q - start_eval;
      rem_eval   = (avail >= AW'(2)) ? 3'd2 : 3'd1;
      cur_eval   = start_eval;
    end else if (hit_up) begin
      ev_eval    = lnedit_pkg::EvUp;
      start_eval = base3;
      rem_eval   = 3'd3;
      cur_eval   = base3;
    end else if (hit_down) begin
      ev_eval    = lnedit_pkg::EvDown;
      start_eval = base3;
      rem_eval   = 3'd3;
      cur_eval   = base3;
    end else if (hit_left) begin
      ev_eval    = lnedit_pkg::EvLeft;
      start_eval = base3;
      rem_eval   = 3'd3;
      cur_eval   = (base3 == '0) ? '0 : base3 - AW'(1);
    end else if (hit_right) begin
      ev_eval    = lnedit_pkg::EvRight;
      start_eval = base3;
      rem_eval   = 3'd3;
      cur_eval   = (base3 < count_q - AW'(3)) ? base3 + AW'(1) : base3;
    end else if (hit_del) begin
      // sequence plus the byte at the cursor when there is one
      ev_eval    = lnedit_pkg::EvDelete;
      start_eval = base4;
      avail      = count_q - base4;
      rem_eval   = (avail >= AW'(5)) ? 3'd5 : 3'd4;
      cur_eval   = base4;
    end
  end

  // length, cursor and pointer next values
  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    if (cmd_i.clear_line) begin
      count_d  = '0;
      cursor_d = '0;
    end
    if (cmd_i.ins_commit) begin
      count_d  = count_q + AW'(1);
      cursor_d = cursor_q + AW'(1);
    end
    if (cmd_i.eval) begin
      count_d  = count_q - AW'(rem_eval);
      cursor_d = cur_eval;
    end
    case (cmd_i.ptr_op)
      lnedit_pkg::PtrCount: ptr_d = count_q;
      lnedit_pkg::PtrZero:  ptr_d = '0;
      lnedit_pkg::PtrDec:   ptr_d = ptr_q - AW'(1);
      lnedit_pkg::PtrInc:   ptr_d = ptr_q + AW'(1);
      default:              ptr_d = ptr_q;
    endcase
    if (cmd_i.eval) begin
      ptr_d = start_eval;
    end
  end

  // read address select
  always_comb begin
    case (cmd_i.rd_sel)
      lnedit_pkg::RdIns: rd_addr = ptr_q - AW'(1);
      lnedit_pkg::RdRem: rd_addr = ptr_q + AW'(rem_q);
      lnedit_pkg::RdWin: rd_addr = cursor_q + AW'(k_q) - AW'(4);
      default:           rd_addr = ptr_q;
    endcase
  end

  assign wr_data = wr_byte_q ? byte_q : rd_data_q;

  // line store, the write is done in the cycle after its command
  always_ff @(posedge clk_i) begin
    if (wr_en_q) begin
      mem_q[wr_addr_q] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cursor_q    <= '0;
      ptr_q       <= '0;
      k_q         <= '0;
      cap_q       <= 1'b0;
      wr_en_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
      ptr_q    <= ptr_d;
      cap_q    <= cmd_i.rd_en && (cmd_i.rd_sel == lnedit_pkg::RdWin);
      wr_en_q  <= cmd_i.wr_en;
      if (cmd_i.rd_en && (cmd_i.rd_sel == lnedit_pkg::RdWin)) begin
        k_q <= k_q + 2'd1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) begin
      byte_q <= key_byte_i;
    end
    if (cmd_i.ev_load) begin
      ev_q <= cmd_i.ev_code;
    end else if (cmd_i.eval) begin
      ev_q <= ev_eval;
    end
    if (cmd_i.eval) begin
      rem_q <= rem_eval;
    end
    if (cmd_i.wr_en) begin
      wr_byte_q <= cmd_i.wr_byte;
      wr_addr_q <= cmd_i.wr_byte ? cursor_q : ptr_q;
    end
    if (cap_q) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= rd_data_q;
    end
    if (cmd_i.out_load) begin
      if (cmd_i.out_sel == lnedit_pkg::OutLine) begin
        out_ev_q   <= lnedit_pkg::EvLineChar;
        out_echo_q <= EchoNewline;
        out_char_q <= rd_data_q;
        out_last_q <= status_o.line_last;
        out_len_q  <= '0;
        out_cur_q  <= '0;
      end else begin
        out_ev_q   <= ev_q;
        out_echo_q <= echo_of(byte_q);
        out_char_q <= 8'd0;
        out_last_q <= 1'b1;
        out_len_q  <= count_q;
        out_cur_q  <= cursor_q;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign event_res_o       = out_ev_q;
  assign echo_char_o       = out_echo_q;
  assign line_char_o       = out_char_q;
  assign last_o            = out_last_q;
  assign line_length_o     = lnedit_pkg::LenW'(out_len_q);
  assign cursor_position_o = lnedit_pkg::LenW'(out_cur_q);

  // checks
  `LEK_ASSERT(a_cursor_in_line, cursor_q <= count_q)
  `LEK_ASSERT(a_commit_grows, cmd_i.ins_commit |=> count_q == AW'($past(count_q) + 1'b1))
  `LEK_ASSERT(a_load_when_free, cmd_i.out_load |-> (!out_valid_q || out_ready_i))
  `LEK_ASSERT(a_eval_ptr_bound, cmd_i.eval |=> ptr_q <= count_q)

endmodule

`default_nettype wire

### rtl/core/line_editor_escape_keys.sv
// ---------------------------------------------------------------------------
// line editor with escape key decoding
// console byte in, edit events and completed line characters out
// ---------------------------------------------------------------------------
//  channel   dir  beat contents
//  s_axis    in   tdata[7:0] key_byte
//  m_axis    out  tuser event_res, tdata echo/line char/length/cursor, tlast
//
//  ordinary byte: the line store, with one port per direction, shifts a byte a cycle
//    to open the gap at the cursor and to close the span removed after a match
//  full line: no insert shift, only the match and the removal; zero byte: no store access
//  line end: one store read per output beat; empty line: no store read
//  reset clears length and cursor at once; the store needs no clearing
//  a new byte is taken while the final beat of the last one waits in the output register
// ---------------------------------------------------------------------------
`default_nettype none

module line_editor_escape_keys (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] key_byte
  input  logic [7:0]  s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] echo_char, [15:8] line_char, [21:16] line_length,
  // [27:22] cursor_position, [31:28] zero
  output logic [31:0] m_axis_tdata_o,
  // [3:0] event_res
  output logic [3:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o
);

  lnedit_pkg::cmd_t    cmd;
  lnedit_pkg::status_t status;
  logic [7:0]          echo_char;
  logic [7:0]          line_char;
  logic [5:0]          line_length;
  logic [5:0]          cursor_position;

  // sequencer
  lnedit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // line store and output register
  lnedit_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .key_byte_i        (s_axis_tdata_i),
    .out_ready_i       (m_axis_tready_i),
    .out_valid_o       (m_axis_tvalid_o),
    .event_res_o       (m_axis_tuser_o),
    .echo_char_o       (echo_char),
    .line_char_o       (line_char),
    .last_o            (m_axis_tlast_o),
    .line_length_o     (line_length),
    .cursor_position_o (cursor_position)
  );

  // output beat packing
  assign m_axis_tdata_o = {4'd0, cursor_position, line_length, line_char, echo_char};

endmodule

`default_nettype wire
